/* hdl/periodic_image_transit_tracker_macros.svh */
// Assertion macros for the transit tracker.
`ifndef PERIODIC_IMAGE_TRANSIT_TRACKER_MACROS_SVH
`define PERIODIC_IMAGE_TRANSIT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PITT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PITT_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define PITT_ASSERT(label, clk, rst_n, prop, msg)
`define PITT_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

/* hdl/pitt_pkg.sv */
// ----------------------------------------------------------------------------
// pitt_pkg
// Types and constants shared by the transit tracker modules.
// ----------------------------------------------------------------------------
package pitt_pkg;
  localparam int unsigned MaxAtomsDef     = 4096;
  localparam int unsigned TransitWidthDef = 16;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_REWIND = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_INV_X = 3'd0,
    CFG_INV_Y = 3'd1,
    CFG_INV_Z = 3'd2,
    CFG_CART  = 3'd3,
    CFG_COUNT = 3'd4
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WALK
  } state_e;

  // Front to back beat: classified and scaled item.
  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] id;
    logic        bad;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
  } item_t;

  // Round Q16.48 product to Q8.24 with saturation.
  function automatic logic [31:0] round_sat(input logic signed [63:0] p);
    logic signed [64:0] s;
    logic signed [40:0] q;
    s = {p[63], p} + 65'sd8388608;
    q = s[64:24];
    if (q > 41'sd2147483647)       round_sat = 32'h7fffffff;
    else if (q < -41'sd2147483648) round_sat = 32'h80000000;
    else                           round_sat = q[31:0];
  endfunction
endpackage

/* hdl/periodic_image_transit_tracker.sv */
// ----------------------------------------------------------------------------
// periodic_image_transit_tracker
// Per-atom periodic unwrapping with transit counts.
// ----------------------------------------------------------------------------
// Usage: drive cmd/atom_id/pos_* with start; an item is taken when start
// is high and busy low. Load and update give one result beat on done_o,
// held one cycle; the receiver cannot stall. Commit and rewind give none.
// The front scales positions when cart is set (one 32x33 multiply per axis,
// then rounding) and hands the item to a two-entry queue. The back reads
// the three stores (one port each), updates and writes back; done_o is
// registered from EXEC. A new item is taken once the front and queue are
// empty, so one can enter while the back still runs the last. Commit/rewind
// walk one entry per cycle over min(atom_count, MaxAtoms). Configuration
// writes (cfg_we_i) must be made only while idle; the block does not
// enforce this. Reset clears control only; stores are undefined until loaded.
// ----------------------------------------------------------------------------
`include "periodic_image_transit_tracker_macros.svh"
module periodic_image_transit_tracker import pitt_pkg::*; #(
  parameter int unsigned MaxAtoms     = MaxAtomsDef,
  parameter int unsigned TransitWidth = TransitWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] atom_id_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  output logic        done_o,
  output logic [11:0] out_atom_o,
  output logic [31:0] frac_x_o,
  output logic [31:0] frac_y_o,
  output logic [31:0] frac_z_o,
  output logic [15:0] transit_x_o,
  output logic [15:0] transit_y_o,
  output logic [15:0] transit_z_o,
  output logic        status_o
);
  logic [31:0] inv_x_q, inv_y_q, inv_z_q;
  logic        cart_q;
  logic [12:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= '0; inv_y_q <= '0; inv_z_q <= '0;
      cart_q  <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INV_X: inv_x_q <= cfg_data_i;
        CFG_INV_Y: inv_y_q <= cfg_data_i;
        CFG_INV_Z: inv_z_q <= cfg_data_i;
        CFG_CART:  cart_q  <= cfg_data_i[0];
        CFG_COUNT: count_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic  push, pop, empty, room, back_idle;
  item_t f_item, q_item;

  pitt_front #(.MaxAtoms(MaxAtoms)) u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i, .atom_id_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .inv_x_i(inv_x_q), .inv_y_i(inv_y_q), .inv_z_i(inv_z_q),
    .cart_i(cart_q), .count_i(count_q), .room_i(room),
    .busy_o(busy), .push_o(push), .item_o(f_item)
  );

  pitt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_item), .pop_i(pop),
    .empty_o(empty), .room_o(room), .data_o(q_item)
  );

  pitt_back #(.MaxAtoms(MaxAtoms), .TransitWidth(TransitWidth)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(q_item), .count_i(count_q),
    .pop_o(pop), .idle_o(back_idle), .done_o,
    .out_atom_o, .frac_x_o, .frac_y_o, .frac_z_o,
    .transit_x_o, .transit_y_o, .transit_z_o, .status_o
  );

  `PITT_ASSERT(a_pop_needs_data, clk_i, rst_ni, pop |-> !empty, "pop from empty queue")
  `PITT_ASSERT(a_pop_when_idle, clk_i, rst_ni, pop |-> back_idle, "pop while back busy")
  `PITT_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && !room && !pop, "queue overflow")
endmodule

/* hdl/pitt_front.sv */
// ----------------------------------------------------------------------------
// pitt_front
// Accepts items, bounds-checks ids, scales positions (if cart_i) in two stages.
// ----------------------------------------------------------------------------
module pitt_front import pitt_pkg::*; #(
  parameter int unsigned MaxAtoms = MaxAtomsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] atom_id_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] inv_x_i,
  input  logic [31:0] inv_y_i,
  input  logic [31:0] inv_z_i,
  input  logic        cart_i,
  input  logic [12:0] count_i,
  input  logic        room_i,
  output logic        busy_o,
  output logic        push_o,
  output item_t       item_o
);
  logic               s1_vld_q, s2_vld_q;
  item_t              s1_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic               accept;
  logic [16:0]        lim;

  assign lim    = (17'(count_i) > 17'(MaxAtoms)) ? 17'(MaxAtoms) : 17'(count_i);
  assign busy_o = s1_vld_q | s2_vld_q | !room_i;
  assign accept = start_i & !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.cmd <= cmd_e'(cmd_i);
      s1_q.id  <= atom_id_i;
      s1_q.bad <= 17'(atom_id_i) >= lim;
      s1_q.fx  <= pos_x_i;
      s1_q.fy  <= pos_y_i;
      s1_q.fz  <= pos_z_i;
      px_q <= $signed(pos_x_i) * $signed({1'b0, inv_x_i});
      py_q <= $signed(pos_y_i) * $signed({1'b0, inv_y_i});
      pz_q <= $signed(pos_z_i) * $signed({1'b0, inv_z_i});
    end
    if (s1_vld_q) begin
      item_o.cmd <= s1_q.cmd;
      item_o.id  <= s1_q.id;
      item_o.bad <= s1_q.bad;
      item_o.fx  <= cart_i ? round_sat(px_q) : s1_q.fx;
      item_o.fy  <= cart_i ? round_sat(py_q) : s1_q.fy;
      item_o.fz  <= cart_i ? round_sat(pz_q) : s1_q.fz;
    end
  end

  assign push_o = s2_vld_q;
endmodule

/* hdl/pitt_queue.sv */
// ----------------------------------------------------------------------------
// pitt_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module pitt_queue import pitt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output logic  room_o,
  output item_t data_o
);
  item_t      mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign empty_o = cnt_q == 2'd0;
  // room only while the queue is empty; front pipe beats are counted in busy_o
  assign room_o  = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule

/* hdl/pitt_back.sv */
// ----------------------------------------------------------------------------
// pitt_back
// Holds the atom stores; runs load, update and the commit/rewind walks.
// ----------------------------------------------------------------------------
module pitt_back import pitt_pkg::*; #(
  parameter int unsigned MaxAtoms     = MaxAtomsDef,
  parameter int unsigned TransitWidth = TransitWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  item_t       item_i,
  input  logic [12:0] count_i,
  output logic        pop_o,
  output logic        idle_o,
  output logic        done_o,
  output logic [11:0] out_atom_o,
  output logic [31:0] frac_x_o,
  output logic [31:0] frac_y_o,
  output logic [31:0] frac_z_o,
  output logic [15:0] transit_x_o,
  output logic [15:0] transit_y_o,
  output logic [15:0] transit_z_o,
  output logic        status_o
);
  localparam int unsigned AW = (MaxAtoms > 1) ? $clog2(MaxAtoms) : 1;
  localparam int unsigned TW = TransitWidth;
  localparam int unsigned RW = 32 + TW;

  logic [95:0]   init_mem [MaxAtoms];
  logic [3*RW-1:0] cur_mem [MaxAtoms];
  logic [3*RW-1:0] prev_mem [MaxAtoms];

  state_e state_q, state_d;
  item_t  it_q;
  logic [16:0] walk_q, walk_d, lim;
  logic [95:0] init_rd_q;
  logic [3*RW-1:0] cur_rd_q, prev_rd_q;
  logic rd_en, walk_rd_q, walk_rd_d;
  logic [AW-1:0] rd_addr;

  assign lim = (17'(count_i) > 17'(MaxAtoms)) ? 17'(MaxAtoms) : 17'(count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      walk_q    <= '0;
      walk_rd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      walk_rd_q <= walk_rd_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    walk_rd_d = 1'b0;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = AW'(it_q.id);
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (item_i.cmd == CMD_COMMIT || item_i.cmd == CMD_REWIND) begin
            state_d = ST_WALK;
            walk_d  = '0;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      ST_WALK: begin
        // read entry walk_q, write it back in the next cycle
        if (walk_q < lim) begin
          rd_en     = 1'b1;
          rd_addr   = walk_q[AW-1:0];
          walk_rd_d = 1'b1;
          walk_d    = walk_q + 17'd1;
        end else if (!walk_rd_q) begin
          walk_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign idle_o = state_q == ST_IDLE;

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (rd_en) begin
      init_rd_q <= init_mem[rd_addr];
      cur_rd_q  <= cur_mem[rd_addr];
      prev_rd_q <= prev_mem[rd_addr];
    end
  end

  // update arithmetic per axis
  logic [31:0]   f  [3];
  logic [31:0]   p  [3];
  logic [TW-1:0] t  [3];
  logic [TW-1:0] tn [3];
  logic [RW-1:0] cur_new [3];
  always_comb begin
    f[0] = it_q.fx; f[1] = it_q.fy; f[2] = it_q.fz;
    for (int a = 0; a < 3; a++) begin
      logic signed [32:0] d;
      logic [32:0] mag;
      p[a] = prev_rd_q[a*RW +: 32];
      t[a] = prev_rd_q[a*RW + 32 +: TW];
      d    = $signed({p[a][31], p[a]}) - $signed({f[a][31], f[a]});
      mag  = d[32] ? 33'(-d) : 33'(d);
      tn[a] = t[a];
      if (mag > 33'd8388608) begin
        if (!d[32]) begin
          if (t[a] != {1'b0, {(TW-1){1'b1}}}) tn[a] = t[a] + TW'(1);
        end else begin
          if (t[a] != {1'b1, {(TW-1){1'b0}}}) tn[a] = t[a] - TW'(1);
        end
      end
      if (it_q.cmd == CMD_LOAD) tn[a] = '0;
      cur_new[a] = {tn[a], f[a]};
    end
  end

  logic [AW-1:0] wb_addr;
  assign wb_addr = 17'(walk_q - 17'd1) < 17'(MaxAtoms) ? AW'(walk_q - 17'd1) : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && !it_q.bad) begin
      cur_mem[AW'(it_q.id)] <= {cur_new[2], cur_new[1], cur_new[0]};
      if (it_q.cmd == CMD_LOAD) begin
        init_mem[AW'(it_q.id)] <= {it_q.fz, it_q.fy, it_q.fx};
        prev_mem[AW'(it_q.id)] <= {cur_new[2], cur_new[1], cur_new[0]};
      end
    end
    if (state_q == ST_WALK && walk_rd_q) begin
      if (it_q.cmd == CMD_COMMIT) prev_mem[wb_addr] <= cur_rd_q;
      else prev_mem[wb_addr] <= {{TW'(0)}, init_rd_q[95:64], {TW'(0)}, init_rd_q[63:32],
                                 {TW'(0)}, init_rd_q[31:0]};
    end
  end

  logic done_q;
  logic [11:0] oa_q;
  logic [31:0] ox_q, oy_q, oz_q;
  logic [15:0] tx_q, ty_q, tz_q;
  logic st_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= state_q == ST_EXEC;
  end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      oa_q <= it_q.id;
      st_q <= it_q.bad;
      ox_q <= it_q.bad ? '0 : f[0];
      oy_q <= it_q.bad ? '0 : f[1];
      oz_q <= it_q.bad ? '0 : f[2];
      tx_q <= it_q.bad ? '0 : 16'($signed(tn[0]));
      ty_q <= it_q.bad ? '0 : 16'($signed(tn[1]));
      tz_q <= it_q.bad ? '0 : 16'($signed(tn[2]));
    end
  end
  assign done_o = done_q;
  assign out_atom_o = oa_q;
  assign frac_x_o = ox_q; assign frac_y_o = oy_q; assign frac_z_o = oz_q;
  assign transit_x_o = tx_q; assign transit_y_o = ty_q; assign transit_z_o = tz_q;
  assign status_o = st_q;
endmodule
